### hdl/sdrm_pkg.sv
// ----------------------------------------------------------------------------
// sdrm_pkg - shared types and codes for the signed rounding divider
// Opcode encodings, output field width and the control bundle that
// travels down the divider array beside the data.
// ----------------------------------------------------------------------------
package sdrm_pkg;

    localparam int unsigned FIELD_W = 64;

    // rounding mode codes; any code with bit 1 set truncates
    localparam logic [1:0] OP_FLOOR = 2'd0;
    localparam logic [1:0] OP_CEIL  = 2'd1;
    localparam logic [1:0] OP_TRUNC = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic       qneg;  // quotient sign
        logic       dneg;  // dividend sign
        logic       vneg;  // divisor sign
        logic       dbz;   // divisor is zero
        logic       dvz;   // dividend is zero
    } sdrm_ctrl_t;

endpackage

### hdl/sdrm_prep.sv
// ----------------------------------------------------------------------------
// sdrm_prep - operand front end
// Takes the low DATA_WIDTH bits of each operand, registers their
// magnitudes and the sign and zero bits of the transaction.
// ----------------------------------------------------------------------------
module sdrm_prep #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [1:0]                     in_mode,
    input  logic [DATA_WIDTH-1:0]          in_dividend,
    input  logic [DATA_WIDTH-1:0]          in_divisor,
    output logic                           out_valid,
    output sdrm_pkg::sdrm_ctrl_t           out_ctrl,
    output logic [DATA_WIDTH-1:0]          out_a,
    output logic [DATA_WIDTH-1:0]          out_b
);
    import sdrm_pkg::*;

    logic                  valid_reg;
    sdrm_ctrl_t            ctrl_reg;
    sdrm_ctrl_t            ctrl_next;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] a_next;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] b_next;

    always_comb
    begin
        ctrl_next.mode = in_mode;
        ctrl_next.dneg = in_dividend[DATA_WIDTH-1];
        ctrl_next.vneg = in_divisor[DATA_WIDTH-1];
        ctrl_next.qneg = in_dividend[DATA_WIDTH-1] ^ in_divisor[DATA_WIDTH-1];
        ctrl_next.dbz  = (in_divisor == '0);
        ctrl_next.dvz  = (in_dividend == '0);
        a_next = in_dividend[DATA_WIDTH-1] ? (~in_dividend + DATA_WIDTH'(1)) : in_dividend;
        b_next = in_divisor[DATA_WIDTH-1] ? (~in_divisor + DATA_WIDTH'(1)) : in_divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;

endmodule

### hdl/sdrm_cell.sv
// ----------------------------------------------------------------------------
// sdrm_cell - one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the freed slot.
// ----------------------------------------------------------------------------
module sdrm_cell #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  sdrm_pkg::sdrm_ctrl_t  in_ctrl,
    input  logic [DATA_WIDTH-1:0] in_r,
    input  logic [DATA_WIDTH-1:0] in_aq,
    input  logic [DATA_WIDTH-1:0] in_b,
    output logic                  out_valid,
    output sdrm_pkg::sdrm_ctrl_t  out_ctrl,
    output logic [DATA_WIDTH-1:0] out_r,
    output logic [DATA_WIDTH-1:0] out_aq,
    output logic [DATA_WIDTH-1:0] out_b
);
    import sdrm_pkg::*;

    logic                  valid_reg;
    sdrm_ctrl_t            ctrl_reg;
    logic [DATA_WIDTH-1:0] r_reg;
    logic [DATA_WIDTH-1:0] r_next;
    logic [DATA_WIDTH-1:0] aq_reg;
    logic [DATA_WIDTH-1:0] aq_next;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // partial remainder stays below the divisor, so the shift never loses a bit
    always_comb
    begin
        trial   = {in_r[DATA_WIDTH-2:0], in_aq[DATA_WIDTH-1]};
        diff    = {1'b0, trial} - {1'b0, in_b};
        fits    = ~diff[DATA_WIDTH];
        r_next  = fits ? diff[DATA_WIDTH-1:0] : trial;
        aq_next = {in_aq[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= in_ctrl;
        r_reg    <= r_next;
        aq_reg   <= aq_next;
        b_reg    <= in_b;
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_r     = r_reg;
    assign out_aq    = aq_reg;
    assign out_b     = b_reg;

endmodule

### hdl/sdrm_post.sv
// ----------------------------------------------------------------------------
// sdrm_post - rounding and sign back end
// Stage one applies the floor or ceiling correction to the truncated
// magnitudes; stage two restores signs, saturates and forces zero cases.
// ----------------------------------------------------------------------------
module sdrm_post #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  sdrm_pkg::sdrm_ctrl_t           in_ctrl,
    input  logic [DATA_WIDTH-1:0]          in_q,
    input  logic [DATA_WIDTH-1:0]          in_r,
    input  logic [DATA_WIDTH-1:0]          in_b,
    output logic                           done,
    output logic [sdrm_pkg::FIELD_W-1:0]   quotient,
    output logic [sdrm_pkg::FIELD_W-1:0]   remainder,
    output logic                           divide_by_zero,
    output logic                           overflow
);
    import sdrm_pkg::*;

    // stage one
    logic                  v1_reg;
    logic [DATA_WIDTH-1:0] qmag_reg;
    logic [DATA_WIDTH-1:0] qmag_next;
    logic [DATA_WIDTH-1:0] rmag_reg;
    logic [DATA_WIDTH-1:0] rmag_next;
    logic                  qneg_reg;
    logic                  rneg_reg;
    logic                  rneg_next;
    logic                  dbz_reg;
    logic                  dvz_reg;
    logic                  inexact;
    logic                  bump;

    // stage two
    logic                  done_reg;
    logic [FIELD_W-1:0]    quot_reg;
    logic [FIELD_W-1:0]    quot_next;
    logic [FIELD_W-1:0]    rem_reg;
    logic [FIELD_W-1:0]    rem_next;
    logic                  dbz_out_reg;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  sat;
    logic [DATA_WIDTH-1:0] qval;
    logic [DATA_WIDTH-1:0] rval;
    logic [DATA_WIDTH-1:0] qmax;

    always_comb
    begin
        inexact   = (in_r != '0);
        bump      = 1'b0;
        rneg_next = in_ctrl.dneg;
        case (in_ctrl.mode)
            OP_FLOOR:
            begin
                bump = in_ctrl.qneg & inexact;
                if (bump)
                begin
                    rneg_next = in_ctrl.vneg;
                end
            end
            OP_CEIL:
            begin
                bump = ~in_ctrl.qneg & inexact;
                if (bump)
                begin
                    rneg_next = ~in_ctrl.vneg;
                end
            end
            default:
            begin
                bump = 1'b0;
            end
        endcase
        qmag_next = in_q + DATA_WIDTH'(bump);
        rmag_next = bump ? (in_b - in_r) : in_r;
    end

    always_ff @(posedge clk)
    begin
        qmag_reg <= qmag_next;
        rmag_reg <= rmag_next;
        qneg_reg <= in_ctrl.qneg;
        rneg_reg <= rneg_next;
        dbz_reg  <= in_ctrl.dbz;
        dvz_reg  <= in_ctrl.dvz;
    end

    always_comb
    begin
        qmax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        sat  = ~qneg_reg & qmag_reg[DATA_WIDTH-1];
        qval = qneg_reg ? (~qmag_reg + DATA_WIDTH'(1)) : qmag_reg;
        rval = rneg_reg ? (~rmag_reg + DATA_WIDTH'(1)) : rmag_reg;
        if (sat)
        begin
            qval = qmax;
            rval = '0;
        end
        ovf_next = sat & ~dbz_reg & ~dvz_reg;
        if (dbz_reg || dvz_reg)
        begin
            qval = '0;
            rval = '0;
        end
        quot_next = FIELD_W'($signed(qval));
        rem_next  = FIELD_W'($signed(rval));
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        dbz_out_reg <= dbz_reg;
        ovf_reg     <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            done_reg <= v1_reg;
        end
    end

    assign done           = done_reg;
    assign quotient       = quot_reg;
    assign remainder      = rem_reg;
    assign divide_by_zero = dbz_out_reg;
    assign overflow       = ovf_reg;

endmodule

### hdl/signed_divide_rounding_modes_unit.sv
// ----------------------------------------------------------------------------
// signed_divide_rounding_modes_unit - pipelined signed divider
// Floor, ceiling or truncating quotient with matching remainder.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with opcode, dividend and divisor; the transaction is taken
//   on any edge where start is high and busy is low. busy stays low, so a
//   new transaction may be issued every cycle.
//   Each transaction returns one result: done is high for a single cycle
//   with quotient, remainder, divide_by_zero and overflow valid.
//   The pipeline has one operand stage, a chain of
//   DATA_WIDTH restoring-division cells (one quotient bit per cell), and two
//   rounding/sign stages. Throughput is one transaction per cycle.
//   Only the low DATA_WIDTH bits of the operands are used; results are
//   sign-extended to 64 bits.
//   Reset clears every valid bit in the chain; transactions in flight are
//   dropped. The receiver cannot stall: results must be taken when done is
//   high.
// ----------------------------------------------------------------------------
module signed_divide_rounding_modes_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic [sdrm_pkg::FIELD_W-1:0] dividend,
    input  logic [sdrm_pkg::FIELD_W-1:0] divisor,
    output logic                         done,
    output logic [sdrm_pkg::FIELD_W-1:0] quotient,
    output logic [sdrm_pkg::FIELD_W-1:0] remainder,
    output logic                         divide_by_zero,
    output logic                         overflow
);
    import sdrm_pkg::*;

    localparam int LATENCY = DATA_WIDTH + 3;

    logic                  accept;
    logic                  chain_valid [0:DATA_WIDTH];
    sdrm_ctrl_t            chain_ctrl  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] chain_r     [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] chain_aq    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] chain_b     [0:DATA_WIDTH];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    sdrm_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .in_mode     (opcode),
        .in_dividend (dividend[DATA_WIDTH-1:0]),
        .in_divisor  (divisor[DATA_WIDTH-1:0]),
        .out_valid   (chain_valid[0]),
        .out_ctrl    (chain_ctrl[0]),
        .out_a       (chain_aq[0]),
        .out_b       (chain_b[0])
    );

    assign chain_r[0] = '0;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        sdrm_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ctrl   (chain_ctrl[i]),
            .in_r      (chain_r[i]),
            .in_aq     (chain_aq[i]),
            .in_b      (chain_b[i]),
            .out_valid (chain_valid[i+1]),
            .out_ctrl  (chain_ctrl[i+1]),
            .out_r     (chain_r[i+1]),
            .out_aq    (chain_aq[i+1]),
            .out_b     (chain_b[i+1])
        );
    end

    sdrm_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (chain_valid[DATA_WIDTH]),
        .in_ctrl        (chain_ctrl[DATA_WIDTH]),
        .in_q           (chain_aq[DATA_WIDTH]),
        .in_r           (chain_r[DATA_WIDTH]),
        .in_b           (chain_b[DATA_WIDTH]),
        .done           (done),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero),
        .overflow       (overflow)
    );

    // every result traces back to a transaction accepted at the input
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without matching transaction");

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> quotient == '0 && remainder == '0 && !overflow)
        else $error("divide by zero result not cleared");

    a_dbz_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> divide_by_zero == ($past(divisor[DATA_WIDTH-1:0], LATENCY) == '0))
        else $error("divide by zero flag does not match divisor");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |->
            quotient == FIELD_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}))
            && remainder == '0)
        else $error("overflow result not saturated");

endmodule

### test/tb_signed_divide_rounding_modes_unit.sv
// ----------------------------------------------------------------------------
// tb_signed_divide_rounding_modes_unit - self-checking bench for the divider
// Directed corner operands, then randomized operand pairs in all rounding
// modes with random sender gaps. Every accepted transaction is predicted and
// checked in order against the done strobe, field by field.
// ----------------------------------------------------------------------------
module tb_signed_divide_rounding_modes_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sdrm_pkg::*;

    localparam int          DATA_W       = 64;
    localparam int          RANDOM_ITEMS = 1530;
    localparam int          QUIET_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = DATA_W + 8;
    // bit 1 set also truncates
    localparam logic [1:0]  OP_TRUNC_ALT = 2'd3;
    localparam logic [63:0] MOST_NEG     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINUS_ONE    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          opcode;
    logic [FIELD_W-1:0]  dividend;
    logic [FIELD_W-1:0]  divisor;
    logic                done;
    logic [FIELD_W-1:0]  quotient;
    logic [FIELD_W-1:0]  remainder;
    logic                divide_by_zero;
    logic                overflow;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [63:0] quotient;
        logic [63:0] remainder;
        logic        dbz;
        logic        ovf;
    } division_t;

    class division_scoreboard;
        division_t pending_divisions[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function logic [63:0] sign_extend(logic [63:0] value);
            logic [63:0] wmask;
            logic [63:0] sbit;
            wmask = {64{1'b1}} >> (64 - DATA_W);
            sbit  = 64'd1 << (DATA_W - 1);
            value = value & wmask;
            if ((value & sbit) != 0)
                value = value | ~wmask;
            return value;
        endfunction

        function division_t predict_division(logic [1:0] op, logic [63:0] d_in,
                                             logic [63:0] v_in);
            logic [63:0] wmask;
            logic [63:0] sbit;
            logic [63:0] d;
            logic [63:0] v;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] q0;
            logic [63:0] r0;
            logic [63:0] qmag;
            logic [63:0] rmag;
            logic        dneg;
            logic        vneg;
            logic        qneg;
            logic        rneg;
            division_t   res;
            wmask = {64{1'b1}} >> (64 - DATA_W);
            sbit  = 64'd1 << (DATA_W - 1);
            d     = d_in & wmask;
            v     = v_in & wmask;
            dneg  = (d & sbit) != 0;
            vneg  = (v & sbit) != 0;
            a     = dneg ? ((64'd0 - d) & wmask) : d;
            b     = vneg ? ((64'd0 - v) & wmask) : v;
            res.op        = op;
            res.dividend  = d_in;
            res.divisor   = v_in;
            res.quotient  = '0;
            res.remainder = '0;
            res.dbz       = 1'b0;
            res.ovf       = 1'b0;
            if (v == 0)
            begin
                res.dbz = 1'b1;
                return res;
            end
            if (d == 0)
                return res;
            q0   = a / b;
            r0   = a % b;
            qneg = dneg != vneg;
            qmag = q0;
            rmag = r0;
            rneg = dneg;
            if (op == OP_FLOOR)
            begin
                if (qneg && r0 != 0)
                begin
                    qmag = q0 + 1;
                    rmag = b - r0;
                    rneg = vneg;
                end
            end
            else if (op == OP_CEIL)
            begin
                if (!qneg && r0 != 0)
                begin
                    qmag = q0 + 1;
                    rmag = b - r0;
                    rneg = !vneg;
                end
            end
            // only most negative / -1 gets here
            if (!qneg && qmag >= sbit)
            begin
                res.quotient = sign_extend(sbit - 1);
                res.ovf      = 1'b1;
                return res;
            end
            res.quotient  = sign_extend(qneg ? 64'd0 - qmag : qmag);
            res.remainder = sign_extend(rneg ? 64'd0 - rmag : rmag);
            return res;
        endfunction

        function void note_operands(logic [1:0] op, logic [63:0] d, logic [63:0] v);
            pending_divisions.push_back(predict_division(op, d, v));
        endfunction

        function int pending();
            return pending_divisions.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string field, logic [63:0] got, logic [63:0] want,
                           division_t e);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h (op %0d, %h / %h)",
                                          field, got, want, e.op, e.dividend,
                                          e.divisor));
        endtask

        task check_result(logic [63:0] q, logic [63:0] r, logic dz, logic ov);
            division_t e;
            if (pending_divisions.size() == 0)
            begin
                report_mismatch($sformatf("result with no transaction pending: q=%h r=%h",
                                          q, r));
                return;
            end
            e = pending_divisions.pop_front();
            compare_field("quotient", q, e.quotient, e);
            compare_field("remainder", r, e.remainder, e);
            compare_field("divide_by_zero", {63'd0, dz}, {63'd0, e.dbz}, e);
            compare_field("overflow", {63'd0, ov}, {63'd0, e.ovf}, e);
        endtask
    endclass

    division_scoreboard sb;
    int                 quiet_cycles = 0;

    signed_divide_rounding_modes_unit #(.DATA_WIDTH(DATA_W)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .dividend       (dividend),
        .divisor        (divisor),
        .done           (done),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero),
        .overflow       (overflow)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // result monitor and stall watchdog
    always @(posedge clk)
    begin
        if (done === 1'b1)
            sb.check_result(quotient, remainder, divide_by_zero, overflow);
        if ((start && busy === 1'b0) || done === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // entered and left at a falling edge
    task issue_division(input logic [1:0] op, input logic [63:0] d, input logic [63:0] v);
        start    <= 1'b1;
        opcode   <= op;
        dividend <= d;
        divisor  <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_operands(op, d, v);
        @(negedge clk);
    endtask

    // idle cycle with junk on the operand ports
    task idle_cycle();
        start    <= 1'b0;
        opcode   <= 2'($urandom);
        dividend <= {$urandom, $urandom};
        divisor  <= {$urandom, $urandom};
        @(negedge clk);
    endtask

    function logic [63:0] random_operand();
        logic [63:0] x;
        case ($urandom_range(0, 9))
            0, 1, 2: x = {$urandom, $urandom};
            3, 4:    x = 64'($urandom_range(0, 40)) - 64'd20;
            5:
            begin
                case ($urandom_range(0, 5))
                    0:       x = 64'd0;
                    1:       x = 64'd1;
                    2:       x = MINUS_ONE;
                    3:       x = MOST_NEG;
                    4:       x = MOST_POS;
                    default: x = MOST_NEG + 64'd1;
                endcase
            end
            default:
            begin
                x = {$urandom, $urandom} >> $urandom_range(0, 63);
                if ($urandom_range(0, 1) == 1)
                    x = 64'd0 - x;
            end
        endcase
        return x;
    endfunction

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_FLOOR;
        dividend     = '0;
        divisor      = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // saturation case in every mode
        issue_division(OP_FLOOR, MOST_NEG, MINUS_ONE);
        issue_division(OP_CEIL, MOST_NEG, MINUS_ONE);
        issue_division(OP_TRUNC, MOST_NEG, MINUS_ONE);
        issue_division(OP_TRUNC_ALT, MOST_NEG, MINUS_ONE);
        // sign combinations, inexact
        issue_division(OP_FLOOR, 64'd7, 64'd2);
        issue_division(OP_FLOOR, -64'sd7, 64'd2);
        issue_division(OP_FLOOR, 64'd7, -64'sd2);
        issue_division(OP_FLOOR, -64'sd7, -64'sd2);
        issue_division(OP_CEIL, 64'd7, 64'd2);
        issue_division(OP_CEIL, -64'sd7, 64'd2);
        issue_division(OP_CEIL, 64'd7, -64'sd2);
        issue_division(OP_CEIL, -64'sd7, -64'sd2);
        issue_division(OP_TRUNC, -64'sd7, 64'd2);
        issue_division(OP_TRUNC_ALT, 64'd7, -64'sd2);
        // zero operands
        issue_division(OP_FLOOR, 64'd0, 64'd0);
        issue_division(OP_CEIL, 64'd0, 64'd5);
        issue_division(OP_TRUNC, 64'd5, 64'd0);
        issue_division(OP_FLOOR, MOST_NEG, 64'd0);
        // range extremes
        issue_division(OP_FLOOR, MOST_POS, MOST_NEG);
        issue_division(OP_CEIL, MOST_NEG, MOST_NEG);
        issue_division(OP_CEIL, MOST_POS, 64'd1);
        issue_division(OP_FLOOR, MOST_NEG, 64'd1);
        issue_division(OP_TRUNC, MOST_POS, MINUS_ONE);
        issue_division(OP_CEIL, 64'd6, 64'd3);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // back-to-back stretch with no gaps
            if (i < 500 || i >= 850)
                while ($urandom_range(0, 99) < 14)
                    idle_cycle();
            // let the pipeline drain completely once
            if (i == 1100)
                while (sb.pending() != 0)
                    idle_cycle();
            issue_division(2'($urandom_range(0, 3)), random_operand(), random_operand());
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
